FILE: rtl/cramt_pkg.sv
package cramt_pkg;

   localparam int DEFAULT_MAX_ELEMENTS = 1024;

   localparam int VALUE_W = 64;
   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;
   localparam int ACT_W   = 2;

   localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ADD  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MIN  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

   localparam logic [VALUE_W-1:0] MIN_IDENTITY = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic latch;
      logic pass_init;
      logic pass_sel;
      logic node_settle;
      logic child_rd;
      logic child_rd_sel;
      logic child_wr;
      logic child_wr_sel;
      logic descend;
      logic to_right;
      logic merge_pop;
      logic pop;
      logic out_load;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic             need_child;
      logic             part;
      logic             stack_empty;
      logic             top_right;
      logic             wrap;
      logic [ACT_W-1:0] act;
      logic             out_full;
      logic             clear_last;
   } status_type;

   function automatic logic [VALUE_W-1:0] smin(input logic [VALUE_W-1:0] a,
                                               input logic [VALUE_W-1:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

endpackage

FILE: rtl/cramt_ctrl.sv
module cramt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [cramt_pkg::ACT_W-1:0]   req_action,
   output logic                          req_ready,
   input  logic                          csr_fire,
   input  cramt_pkg::status_type         status,
   output cramt_pkg::cmd_type            cmd
);
   import cramt_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_START = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_SET   = 4'd4;
   localparam logic [3:0] S_CRD0  = 4'd5;
   localparam logic [3:0] S_CWR0  = 4'd6;
   localparam logic [3:0] S_CWR1  = 4'd7;
   localparam logic [3:0] S_NEXT  = 4'd8;
   localparam logic [3:0] S_RET   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       second_ff, second_in;

   assign req_ready = (state_ff == S_IDLE) && !csr_fire;

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            second_in = 1'b0;
            if (req_valid && req_ready) begin
               cmd.latch = 1'b1;
               if (req_action != ACT_NONE) state_in = S_START;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_START: begin
            cmd.pass_init = 1'b1;
            cmd.pass_sel  = second_ff;
            state_in      = S_RD;
         end
         S_RD: begin
            state_in = S_SET;   // memory read of the current node
         end
         S_SET: begin
            cmd.node_settle = 1'b1;
            state_in = status.need_child ? S_CRD0 : S_NEXT;
         end
         S_CRD0: begin
            cmd.child_rd     = 1'b1;
            cmd.child_rd_sel = 1'b0;
            state_in         = S_CWR0;
         end
         S_CWR0: begin
            cmd.child_wr     = 1'b1;
            cmd.child_wr_sel = 1'b0;
            cmd.child_rd     = 1'b1;
            cmd.child_rd_sel = 1'b1;
            state_in         = S_CWR1;
         end
         S_CWR1: begin
            cmd.child_wr     = 1'b1;
            cmd.child_wr_sel = 1'b1;
            state_in         = S_NEXT;
         end
         S_NEXT: begin
            if (status.part) begin
               cmd.descend = 1'b1;
               state_in    = S_RD;
            end else begin
               state_in = S_RET;
            end
         end
         S_RET: begin
            if (status.stack_empty) begin
               if ((status.act == ACT_ADD || status.act == ACT_MIN) && status.wrap &&
                   !second_ff) begin
                  second_in = 1'b1;
                  state_in  = S_START;
               end else begin
                  second_in = 1'b0;
                  state_in  = (status.act == ACT_MIN) ? S_OUT : S_IDLE;
               end
            end else if (!status.top_right) begin
               cmd.to_right = 1'b1;
               state_in     = S_RD;
            end else if (status.act == ACT_MIN) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.merge_pop = 1'b1;
            end
         end
         S_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_fire) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

FILE: rtl/cramt_dp.sv
module cramt_dp #(
   parameter int MAX_ELEMENTS = cramt_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_fire,
   input  logic [cramt_pkg::COUNT_W-1:0] csr_element_count,
   input  logic [cramt_pkg::ACT_W-1:0]   req_action,
   input  logic [cramt_pkg::POS_W-1:0]   req_left,
   input  logic [cramt_pkg::POS_W-1:0]   req_right,
   input  logic [cramt_pkg::VALUE_W-1:0] req_value,
   input  cramt_pkg::cmd_type            cmd,
   output cramt_pkg::status_type         status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cramt_pkg::VALUE_W-1:0] rsp_min_value
);
   import cramt_pkg::*;

   localparam int PW    = $clog2(MAX_ELEMENTS);
   localparam int IW    = PW + 1;
   localparam int NODES = 2 * MAX_ELEMENTS;
   localparam int QW    = (PW > POS_W) ? PW : POS_W;
   localparam int SD    = PW;
   localparam int SIW   = (SD > 1) ? $clog2(SD) : 1;
   localparam int SW    = $clog2(SD + 1);
   localparam logic [IW:0]   NODES_V  = (IW + 1)'(NODES);
   localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
   localparam logic [PW-1:0] LAST_MAX = PW'(MAX_ELEMENTS - 1);

   function automatic logic idx_ok(input logic [IW-1:0] i);
      return {1'b0, i} < NODES_V;
   endfunction

   function automatic logic [PW-1:0] midpoint(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PW:1];
   endfunction

   // node store: {pending add, node min}
   logic [2*VALUE_W-1:0] tree_mem [NODES];
   logic [2*VALUE_W-1:0] rd_ff;
   logic                 rd_ok_ff;

   logic [PW-1:0]      last_ff, last_in;
   logic [ACT_W-1:0]   act_ff;
   logic [POS_W-1:0]   l_ff, r_ff;
   logic [VALUE_W-1:0] v_ff;
   logic [QW-1:0]      rng_l_ff, rng_r_ff;
   logic [IW-1:0]      k_ff;
   logic [PW-1:0]      lo_ff, hi_ff;
   logic [VALUE_W-1:0] amt_ff, ret_ff, acc_ff;
   logic               part_ff;
   logic [SW-1:0]      sp_ff;
   logic [IW-1:0]      clr_ptr_ff;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_min_ff;

   logic [IW-1:0]      stk_k    [SD];
   logic [PW-1:0]      stk_lo   [SD];
   logic [PW-1:0]      stk_hi   [SD];
   logic               stk_right[SD];
   logic [VALUE_W-1:0] stk_lmin [SD];

   logic [SIW-1:0]       top, push;
   logic [VALUE_W-1:0]   mem_min, mem_pend, settled, new_min, amt_in, merged;
   logic                 node_ok, outside, covered, leaf, is_add, is_load;
   logic [QW-1:0]        lo_q, hi_q;
   logic                 we;
   logic [IW-1:0]        waddr, raddr, child_w;
   logic [2*VALUE_W-1:0] wdata;

   assign top  = SIW'(sp_ff - 1'b1);
   assign push = SIW'(sp_ff);

   always_comb begin
      if (csr_element_count == '0) begin
         last_in = '0;
      end else if (int'(csr_element_count) > MAX_ELEMENTS) begin
         last_in = LAST_MAX;
      end else begin
         last_in = PW'(csr_element_count - 1'b1);
      end
   end

   // bring the node up to date and classify it against the range
   always_comb begin
      mem_min  = rd_ok_ff ? rd_ff[VALUE_W-1:0] : '0;
      mem_pend = rd_ok_ff ? rd_ff[2*VALUE_W-1:VALUE_W] : '0;
      settled  = mem_min + mem_pend;
      node_ok  = idx_ok(k_ff);
      lo_q     = QW'(lo_ff);
      hi_q     = QW'(hi_ff);
      outside  = (lo_q > rng_r_ff) || (hi_q < rng_l_ff);
      covered  = !outside && (lo_q >= rng_l_ff) && (hi_q <= rng_r_ff);
      leaf     = (lo_ff == hi_ff);
      is_add   = (act_ff == ACT_ADD);
      is_load  = (act_ff == ACT_LOAD);
      if (covered && is_add) begin
         new_min = settled + v_ff;
         amt_in  = mem_pend + v_ff;
      end else if (covered && is_load) begin
         new_min = v_ff;
         amt_in  = mem_pend;
      end else begin
         new_min = settled;
         amt_in  = mem_pend;
      end
      merged = smin(stk_lmin[top], ret_ff);
   end

   always_comb begin
      child_w = {k_ff[IW-2:0], cmd.child_wr_sel};
      raddr   = cmd.child_rd ? {k_ff[IW-2:0], cmd.child_rd_sel} : k_ff;
      we      = 1'b0;
      waddr   = k_ff;
      wdata   = '0;
      if (cmd.clear_step) begin
         we    = 1'b1;
         waddr = clr_ptr_ff;
      end else if (cmd.node_settle) begin
         we    = node_ok;
         wdata = {{VALUE_W{1'b0}}, new_min};
      end else if (cmd.child_wr) begin
         we    = idx_ok(child_w);
         waddr = child_w;
         wdata = {mem_pend + amt_ff, mem_min};
      end else if (cmd.merge_pop) begin
         we    = idx_ok(stk_k[top]);
         waddr = stk_k[top];
         wdata = {{VALUE_W{1'b0}}, merged};
      end
   end

   always_ff @(posedge clock) begin
      if (we) tree_mem[waddr] <= wdata;
      rd_ff    <= tree_mem[raddr];
      rd_ok_ff <= idx_ok(raddr);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff <= req_action;
         l_ff   <= req_left;
         r_ff   <= req_right;
         v_ff   <= req_value;
         acc_ff <= MIN_IDENTITY;
      end else if (cmd.node_settle && covered && act_ff == ACT_MIN) begin
         acc_ff <= smin(acc_ff, settled);
      end
      if (cmd.pass_init) begin
         if (cmd.pass_sel) begin
            rng_l_ff <= '0;
            rng_r_ff <= QW'(r_ff);
         end else if (act_ff == ACT_LOAD) begin
            rng_l_ff <= QW'(l_ff);
            rng_r_ff <= QW'(l_ff);
         end else if (l_ff <= r_ff) begin
            rng_l_ff <= QW'(l_ff);
            rng_r_ff <= QW'(r_ff);
         end else begin
            rng_l_ff <= QW'(l_ff);
            rng_r_ff <= QW'(last_ff);
         end
         k_ff  <= IW'(1);
         lo_ff <= '0;
         hi_ff <= last_ff;
      end else if (cmd.descend) begin
         k_ff  <= {k_ff[IW-2:0], 1'b0};
         hi_ff <= midpoint(lo_ff, hi_ff);
      end else if (cmd.to_right) begin
         k_ff  <= {stk_k[top][IW-2:0], 1'b1};
         lo_ff <= midpoint(stk_lo[top], stk_hi[top]) + 1'b1;
         hi_ff <= stk_hi[top];
      end
      if (cmd.node_settle) begin
         amt_ff  <= amt_in;
         ret_ff  <= node_ok ? new_min : '0;
         part_ff <= !outside && !covered;
      end else if (cmd.merge_pop) begin
         ret_ff <= merged;
      end
      if (cmd.descend) begin
         stk_k[push]     <= k_ff;
         stk_lo[push]    <= lo_ff;
         stk_hi[push]    <= hi_ff;
         stk_right[push] <= 1'b0;
      end else if (cmd.to_right) begin
         stk_right[top] <= 1'b1;
         stk_lmin[top]  <= ret_ff;
      end
      if (cmd.out_load) rsp_min_ff <= acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= LAST_MAX;
         sp_ff        <= '0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) last_ff <= last_in;
         if (cmd.pass_init) begin
            sp_ff <= '0;
         end else if (cmd.descend) begin
            sp_ff <= sp_ff + 1'b1;
         end else if (cmd.merge_pop || cmd.pop) begin
            sp_ff <= sp_ff - 1'b1;
         end
         if (csr_fire) begin
            clr_ptr_ff <= '0;
         end else if (cmd.clear_step) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.need_child  = !leaf && (amt_in != '0);
      status.part        = part_ff;
      status.stack_empty = (sp_ff == '0);
      status.top_right   = stk_right[top];
      status.wrap        = (l_ff > r_ff);
      status.act         = act_ff;
      status.out_full    = rsp_valid_ff;
      status.clear_last  = (clr_ptr_ff == LAST_IDX);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_ff;

endmodule

FILE: rtl/circular_range_add_min_tree_top.sv
// channel | direction | ports
// req     | in        | req_valid/req_ready, req_action, req_left, req_right, req_value
// rsp     | out       | rsp_valid/rsp_ready, rsp_min_value
// csr     | in        | csr_valid/csr_ready, csr_element_count
//
// Each tree node visit runs read, settle and decide steps, with reads and writes of both
// children added when a pending add is pushed down; each return to a parent is a step of its
// own. The single-port node memory sets this pace: an item ends early when the root alone
// decides it and runs longest on two full boundary paths, twice as long when wrapped.
// After reset and after every csr write the node memory is swept to zero with req_ready low.
// A waiting rsp word does not block the next req word, though a later min result waits for it.
module circular_range_add_min_tree_top #(
   parameter int MAX_ELEMENTS = cramt_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cramt_pkg::ACT_W-1:0]   req_action,
   input  logic [cramt_pkg::POS_W-1:0]   req_left,
   input  logic [cramt_pkg::POS_W-1:0]   req_right,
   input  logic [cramt_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cramt_pkg::VALUE_W-1:0] rsp_min_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cramt_pkg::COUNT_W-1:0] csr_element_count
);
   import cramt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   cramt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .csr_fire   (csr_fire),
      .status     (status),
      .cmd        (cmd)
   );

   cramt_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_fire          (csr_fire),
      .csr_element_count (csr_element_count),
      .req_action        (req_action),
      .req_left          (req_left),
      .req_right         (req_right),
      .req_value         (req_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_min_value     (rsp_min_value)
   );

endmodule

FILE: rtl/cramt_props.sv
module cramt_props (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [cramt_pkg::ACT_W-1:0]   req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cramt_pkg::VALUE_W-1:0] rsp_min_value,
   input logic                          csr_valid,
   input logic                          csr_ready
);
   import cramt_pkg::*;

   // memory sweep follows reset
   a_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("req_ready high right after reset");

   a_csr_sweep: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("req_ready high right after csr write");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action != ACT_NONE |=> !req_ready)
      else $error("new word taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_value))
      else $error("rsp word dropped or changed while stalled");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp word appeared without a query in work");

endmodule

bind circular_range_add_min_tree_top cramt_props u_props (.*);

FILE: dv/circular_range_min_checker.sv
`timescale 1ns / 100ps

module circular_range_min_checker #(
   parameter int MAX_ELEMENTS = cramt_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [cramt_pkg::ACT_W-1:0]   req_action,
   input  logic [cramt_pkg::POS_W-1:0]   req_left,
   input  logic [cramt_pkg::POS_W-1:0]   req_right,
   input  logic [cramt_pkg::VALUE_W-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [cramt_pkg::VALUE_W-1:0] rsp_min_value,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [cramt_pkg::COUNT_W-1:0] csr_element_count,
   output int                            mismatches,
   output int                            awaited
);
   import cramt_pkg::*;

   localparam int NODES = 2 * MAX_ELEMENTS;

   bit [VALUE_W-1:0] tree_min[NODES];
   bit [VALUE_W-1:0] tree_pend[NODES];
   bit               tree_pend_v[NODES];
   int unsigned      elem_count;
   bit [VALUE_W-1:0] min_words[$];

   function automatic bit [VALUE_W-1:0] smaller(bit [VALUE_W-1:0] a, bit [VALUE_W-1:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic bit [VALUE_W-1:0] node_val(int unsigned k);
      return (k < NODES) ? tree_min[k] : '0;
   endfunction

   function automatic void clear_tree();
      for (int i = 0; i < NODES; i++) begin
         tree_min[i] = '0;
         tree_pend[i] = '0;
         tree_pend_v[i] = 1'b0;
      end
   endfunction

   function automatic void defer_add(int unsigned c, bit [VALUE_W-1:0] v);
      if (c < NODES) begin
         tree_pend[c] += v;
         tree_pend_v[c] = 1'b1;
      end
   endfunction

   // apply a deferred add to the node and, above a leaf, hand it to both children
   function automatic void push_down(int unsigned k, int unsigned lo, int unsigned hi);
      if (k >= NODES || !tree_pend_v[k]) return;
      tree_min[k] += tree_pend[k];
      if (lo != hi) begin
         defer_add(2 * k, tree_pend[k]);
         defer_add(2 * k + 1, tree_pend[k]);
      end
      tree_pend[k] = '0;
      tree_pend_v[k] = 1'b0;
   endfunction

   function automatic void refresh(int unsigned k);
      if (k < NODES) tree_min[k] = smaller(node_val(2 * k), node_val(2 * k + 1));
   endfunction

   function automatic void add_span(int unsigned k, int unsigned lo, int unsigned hi,
                                    int unsigned l, int unsigned r, bit [VALUE_W-1:0] v);
      int unsigned mid;
      push_down(k, lo, hi);
      if (lo > r || hi < l) return;
      if (lo >= l && hi <= r) begin
         if (k < NODES) tree_min[k] += v;
         if (lo != hi) begin
            defer_add(2 * k, v);
            defer_add(2 * k + 1, v);
         end
         return;
      end
      mid = (lo + hi) / 2;
      add_span(2 * k, lo, mid, l, r, v);
      add_span(2 * k + 1, mid + 1, hi, l, r, v);
      refresh(k);
   endfunction

   function automatic void set_elem(int unsigned k, int unsigned lo, int unsigned hi,
                                    int unsigned pos, bit [VALUE_W-1:0] v);
      int unsigned mid;
      push_down(k, lo, hi);
      if (lo > pos || hi < pos) return;
      if (lo == hi) begin
         if (k < NODES) tree_min[k] = v;
         return;
      end
      mid = (lo + hi) / 2;
      set_elem(2 * k, lo, mid, pos, v);
      set_elem(2 * k + 1, mid + 1, hi, pos, v);
      refresh(k);
   endfunction

   function automatic bit [VALUE_W-1:0] span_min(int unsigned k, int unsigned lo,
                                                 int unsigned hi, int unsigned l,
                                                 int unsigned r);
      int unsigned mid;
      push_down(k, lo, hi);
      if (lo > r || hi < l) return MIN_IDENTITY;
      if (lo >= l && hi <= r) return node_val(k);
      mid = (lo + hi) / 2;
      return smaller(span_min(2 * k, lo, mid, l, r), span_min(2 * k + 1, mid + 1, hi, l, r));
   endfunction

   task automatic report(string what, bit [VALUE_W-1:0] got, bit [VALUE_W-1:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      int unsigned last, l, r;
      bit [VALUE_W-1:0] want;
      if (reset) begin
         clear_tree();
         elem_count = MAX_ELEMENTS;
         min_words.delete();
         mismatches = 0;
         awaited = 0;
      end else begin
         // response first: it answers a word taken earlier
         if (rsp_valid && rsp_ready) begin
            if (min_words.size() == 0) report("unexpected rsp word", rsp_min_value, '0);
            else begin
               want = min_words.pop_front();
               if (rsp_min_value !== want) report("min_value", rsp_min_value, want);
            end
         end
         if (csr_valid && csr_ready) begin
            elem_count = csr_element_count;
            if (elem_count < 1) elem_count = 1;
            if (elem_count > MAX_ELEMENTS) elem_count = MAX_ELEMENTS;
            clear_tree();
         end
         if (req_valid && req_ready) begin
            last = elem_count - 1;
            l = req_left;
            r = req_right;
            case (req_action)
               ACT_LOAD: set_elem(1, 0, last, l, req_value);
               ACT_ADD: begin
                  if (l <= r) add_span(1, 0, last, l, r, req_value);
                  else begin
                     add_span(1, 0, last, l, last, req_value);
                     add_span(1, 0, last, 0, r, req_value);
                  end
               end
               ACT_MIN: begin
                  if (l <= r) want = span_min(1, 0, last, l, r);
                  else want = smaller(span_min(1, 0, last, l, last), span_min(1, 0, last, 0, r));
                  min_words = {min_words, want};
               end
               default: ;
            endcase
         end
         awaited = min_words.size();
      end
   end

endmodule

FILE: dv/circular_range_add_min_tree_top_test.sv
`timescale 1ns / 100ps

module circular_range_add_min_tree_top_test;
   import cramt_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid, req_ready;
   logic [ACT_W-1:0]   req_action;
   logic [POS_W-1:0]   req_left, req_right;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid, rsp_ready;
   logic [VALUE_W-1:0] rsp_min_value;
   logic               csr_valid, csr_ready;
   logic [COUNT_W-1:0] csr_element_count;
   int                 mismatches, awaited;

   bit gaps_on;
   bit hold_now;
   bit long_hold_done;
   int unsigned cur_count;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   circular_range_add_min_tree_top dut (.*);
   circular_range_min_checker chk (.*);

   initial begin
      #300_000_000;
      $display("circular_range_add_min_tree_top test failed");
      $finish;
   end

   // rsp side: random stalls, plus one long hold when asked
   initial begin
      long_hold_done = 1'b0;
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_now && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send(logic [ACT_W-1:0] a, int unsigned l, int unsigned r,
                       logic [VALUE_W-1:0] v);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= a;
      req_left <= l[POS_W-1:0];
      req_right <= r[POS_W-1:0];
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // block idle and every rsp word taken
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (!req_ready || awaited != 0) @(posedge clock);
   endtask

   task automatic set_count(int unsigned c);
      drain();
      csr_valid <= 1'b1;
      csr_element_count <= c[COUNT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_count = c < 1 ? 1 : (c > DEFAULT_MAX_ELEMENTS ? DEFAULT_MAX_ELEMENTS : c);
   endtask

   function automatic int unsigned pick_pos();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
      return $urandom_range(0, cur_count - 1);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
         2: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
         default: return {{48{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      endcase
   endfunction

   task automatic random_words(int n);
      int unsigned w;
      logic [ACT_W-1:0] a;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(0, 19);
         a = w < 5 ? ACT_LOAD : (w < 11 ? ACT_ADD : (w < 19 ? ACT_MIN : ACT_NONE));
         send(a, pick_pos(), pick_pos(), pick_value());
      end
   endtask

   initial begin
      int unsigned counts[7];
      counts = '{2047, 37, 1, 1000, 0, 2, 1024};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_NONE;
      req_left <= '0;
      req_right <= '0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_element_count <= '0;
      gaps_on = 1'b1;
      hold_now = 1'b0;
      cur_count = DEFAULT_MAX_ELEMENTS;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, wraps, unused action
      send(ACT_MIN, 0, 1023, '0);
      send(ACT_LOAD, 0, 0, 64'h8000_0000_0000_0000);
      send(ACT_LOAD, 1023, 0, 64'h7FFF_FFFF_FFFF_FFFF);
      send(ACT_MIN, 0, 1023, '0);
      send(ACT_MIN, 1023, 0, '0);
      send(ACT_MIN, 1000, 5, '0);
      send(ACT_ADD, 1000, 5, 64'hFFFF_FFFF_FFFF_FFFF);
      send(ACT_MIN, 1023, 1023, '0);
      send(ACT_ADD, 0, 1023, 64'h8000_0000_0000_0000);
      send(ACT_MIN, 0, 0, '0);
      send(ACT_MIN, 1, 1022, '0);
      send(ACT_NONE, 3, 7, 64'h1234);
      send(ACT_LOAD, 512, 0, 64'd5);
      send(ACT_ADD, 511, 513, 64'h7FFF_FFFF_FFFF_FFFF);
      send(ACT_MIN, 510, 514, '0);
      send(ACT_MIN, 600, 599, '0);
      set_count(2);
      send(ACT_LOAD, 700, 0, 64'd9);
      send(ACT_MIN, 5, 9, '0);
      send(ACT_MIN, 1, 0, '0);
      send(ACT_ADD, 3, 0, 64'd4);
      send(ACT_MIN, 0, 1, '0);

      foreach (counts[i]) begin
         set_count(counts[i]);
         gaps_on = (i != 6) && $urandom_range(0, 3) != 0;
         if (i == 1) begin
            hold_now = 1'b1;
            gaps_on = 1'b0;
            for (int j = 0; j < 20; j++) send(ACT_MIN, pick_pos(), pick_pos(), '0);
         end
         random_words(i == 6 ? 150 : 230);
      end
      drain();
      if (mismatches == 0 && awaited == 0)
         $display("circular_range_add_min_tree_top test passed");
      else
         $display("circular_range_add_min_tree_top test failed");
      $finish;
   end

endmodule
